[design/rmq_pkg.sv]
// Shared constants and types for the rotation matrix to quaternion block.
// Depends on nothing; imported by rotation_matrix_to_quaternion, rmq_checker and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package rmq_pkg;

   localparam int DATA_W    = 16;
   localparam int FRAC_BITS = 14;
   localparam int ONE       = 1 << FRAC_BITS;
   localparam int HALF      = ONE / 2;

   // trace sum and pair sum widths
   localparam int T_W = DATA_W + 2;
   localparam int D_W = DATA_W + 1;

   // square root: positive trace sum shifted up by FRAC_BITS, two bits per step
   localparam int SQ_STEPS = (T_W - 1 + FRAC_BITS + 1) / 2;
   localparam int SQ_W     = 2 * SQ_STEPS;
   localparam int R_W      = SQ_STEPS + 3;

   // root component and divisor
   localparam int C_W   = SQ_STEPS - 1;
   localparam int DEN_W = C_W + 2;

   // division: magnitude scaled by FRAC_BITS plus half the divisor
   localparam int N_W     = D_W + FRAC_BITS + 1;
   localparam int Q_STEPS = N_W - FRAC_BITS - 1;

   localparam int LATENCY = SQ_STEPS + Q_STEPS + 4;

   localparam logic [1:0] IDX_X = 2'd0;
   localparam logic [1:0] IDX_Y = 2'd1;
   localparam logic [1:0] IDX_Z = 2'd2;
   localparam logic [1:0] IDX_W = 2'd3;

   typedef struct packed {
      logic [1:0]            best;
      logic [2:0][D_W-1:0]   d;
      logic [SQ_W-1:0]       rad;
      logic [SQ_STEPS-1:0]   root;
      logic [R_W-1:0]        rem;
   } sq_stage_type;

   typedef struct packed {
      logic [1:0]              best;
      logic [C_W-1:0]          c;
      logic [DEN_W-1:0]        den;
      logic [2:0]              neg;
      logic [2:0][N_W-1:0]     num;
      logic [2:0][DEN_W-1:0]   rem;
      logic [2:0][Q_STEPS-1:0] quo;
   } dv_stage_type;

endpackage

`default_nettype wire

[design/rotation_matrix_to_quaternion.sv]
// Rotation matrix to quaternion (Shepperd's method), fully pipelined.
// Depends on rmq_pkg for widths, component codes and stage types.
// Throughput: one matrix per cycle; busy stays low and the receiver cannot
// stall. Depth is set by the 16-step square root pipeline and the 17-step
// restoring divider pipeline.
// Synchronous reset clears all valid bits; no result leaves after reset.
`timescale 1ns / 1ps
`default_nettype none

module rotation_matrix_to_quaternion (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_start,
   output logic                                busy,
   input  wire  logic signed [rmq_pkg::DATA_W-1:0] req_m11,
   input  wire  logic signed [rmq_pkg::DATA_W-1:0] req_m12,
   input  wire  logic signed [rmq_pkg::DATA_W-1:0] req_m13,
   input  wire  logic signed [rmq_pkg::DATA_W-1:0] req_m21,
   input  wire  logic signed [rmq_pkg::DATA_W-1:0] req_m22,
   input  wire  logic signed [rmq_pkg::DATA_W-1:0] req_m23,
   input  wire  logic signed [rmq_pkg::DATA_W-1:0] req_m31,
   input  wire  logic signed [rmq_pkg::DATA_W-1:0] req_m32,
   input  wire  logic signed [rmq_pkg::DATA_W-1:0] req_m33,
   output logic                                rsp_strobe,
   output logic signed [rmq_pkg::DATA_W-1:0]   rsp_qx,
   output logic signed [rmq_pkg::DATA_W-1:0]   rsp_qy,
   output logic signed [rmq_pkg::DATA_W-1:0]   rsp_qz,
   output logic signed [rmq_pkg::DATA_W-1:0]   rsp_qw,
   output logic [1:0]                          rsp_largest_index
);
   import rmq_pkg::*;

   // stage 1: trace sums and pair sums
   logic                        s1_vld_ff;
   logic signed [T_W-1:0]       t_ff [4];
   logic signed [D_W-1:0]       sxy_ff, sxz_ff, syz_ff, dx_ff, dy_ff, dz_ff;

   // square root and divider pipelines
   logic         sq_vld_ff [SQ_STEPS+1];
   sq_stage_type sq_ff     [SQ_STEPS+1];
   sq_stage_type sq_in     [SQ_STEPS+1];
   logic [R_W-1:0] sq_r2    [SQ_STEPS];
   logic [R_W-1:0] sq_trial [SQ_STEPS];

   logic         dv_vld_ff [Q_STEPS+1];
   dv_stage_type dv_ff     [Q_STEPS+1];
   dv_stage_type dv_in     [Q_STEPS+1];
   logic [DEN_W:0] dv_r2   [Q_STEPS][3];

   // selection stage
   logic [1:0]             sel_best;
   logic signed [T_W-1:0]  sel_t;

   // divider setup
   logic [C_W-1:0]         set_c;
   logic [D_W-1:0]         set_mag [3];

   // output stage
   logic [DATA_W-1:0]      fin_comp [3];
   logic [Q_STEPS-1:0]     fin_mag  [3];
   logic [DATA_W-1:0]      fin_root;

   logic                   accept;

   assign busy   = 1'b0;
   assign accept = req_start && !busy;

   // ---------------- stage 1 ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= accept;
      end
      t_ff[0] <= T_W'(ONE) + T_W'(req_m11) - T_W'(req_m22) - T_W'(req_m33);
      t_ff[1] <= T_W'(ONE) - T_W'(req_m11) + T_W'(req_m22) - T_W'(req_m33);
      t_ff[2] <= T_W'(ONE) - T_W'(req_m11) - T_W'(req_m22) + T_W'(req_m33);
      t_ff[3] <= T_W'(ONE) + T_W'(req_m11) + T_W'(req_m22) + T_W'(req_m33);
      sxy_ff  <= D_W'(req_m12) + D_W'(req_m21);
      sxz_ff  <= D_W'(req_m31) + D_W'(req_m13);
      syz_ff  <= D_W'(req_m23) + D_W'(req_m32);
      dx_ff   <= D_W'(req_m23) - D_W'(req_m32);
      dy_ff   <= D_W'(req_m31) - D_W'(req_m13);
      dz_ff   <= D_W'(req_m12) - D_W'(req_m21);
   end

   always_comb begin
      // ---------------- stage 2: pick largest, lowest index on a tie ----------------
      sel_best = IDX_X;
      sel_t    = t_ff[0];
      if (t_ff[1] > sel_t) begin
         sel_best = IDX_Y;
         sel_t    = t_ff[1];
      end
      if (t_ff[2] > sel_t) begin
         sel_best = IDX_Z;
         sel_t    = t_ff[2];
      end
      if (t_ff[3] > sel_t) begin
         sel_best = IDX_W;
         sel_t    = t_ff[3];
      end

      sq_in[0].best = sel_best;
      sq_in[0].rad  = SQ_W'({sel_t[T_W-2:0], {FRAC_BITS{1'b0}}});
      sq_in[0].root = '0;
      sq_in[0].rem  = '0;
      unique case (sel_best)
         IDX_X: sq_in[0].d = {dx_ff, sxz_ff, sxy_ff};
         IDX_Y: sq_in[0].d = {dy_ff, syz_ff, sxy_ff};
         IDX_Z: sq_in[0].d = {dz_ff, syz_ff, sxz_ff};
         default: sq_in[0].d = {dz_ff, dy_ff, dx_ff};
      endcase

      // ---------------- square root, one result bit per stage ----------------
      for (int k = 0; k < SQ_STEPS; k++) begin
         sq_r2[k]    = {sq_ff[k].rem[R_W-3:0], sq_ff[k].rad[SQ_W-1 -: 2]};
         sq_trial[k] = {1'b0, sq_ff[k].root, 2'b01};
         sq_in[k+1]      = sq_ff[k];
         sq_in[k+1].rad  = {sq_ff[k].rad[SQ_W-3:0], 2'b00};
         if (sq_r2[k] >= sq_trial[k]) begin
            sq_in[k+1].rem  = sq_r2[k] - sq_trial[k];
            sq_in[k+1].root = {sq_ff[k].root[SQ_STEPS-2:0], 1'b1};
         end else begin
            sq_in[k+1].rem  = sq_r2[k];
            sq_in[k+1].root = {sq_ff[k].root[SQ_STEPS-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      // ---------------- divider setup ----------------
      set_c        = sq_ff[SQ_STEPS].root[SQ_STEPS-1:1];
      dv_in[0].best = sq_ff[SQ_STEPS].best;
      dv_in[0].c    = set_c;
      dv_in[0].den  = {set_c, 2'b00};
      dv_in[0].quo  = '0;
      for (int j = 0; j < 3; j++) begin
         dv_in[0].neg[j] = sq_ff[SQ_STEPS].d[j][D_W-1];
         set_mag[j] = dv_in[0].neg[j] ? D_W'(-sq_ff[SQ_STEPS].d[j])
                                      : sq_ff[SQ_STEPS].d[j];
         // add half the divisor to round to nearest, ties away from zero
         dv_in[0].num[j] = N_W'({set_mag[j], {FRAC_BITS{1'b0}}}) + N_W'({set_c, 1'b0});
         dv_in[0].rem[j] = DEN_W'(dv_in[0].num[j][N_W-1:Q_STEPS]);
      end

      // ---------------- restoring division, one quotient bit per stage ----------------
      for (int k = 0; k < Q_STEPS; k++) begin
         dv_in[k+1] = dv_ff[k];
         for (int j = 0; j < 3; j++) begin
            dv_r2[k][j] = {dv_ff[k].rem[j], dv_ff[k].num[j][Q_STEPS-1-k]};
            if (dv_r2[k][j] >= (DEN_W+1)'(dv_ff[k].den)) begin
               dv_in[k+1].rem[j] = DEN_W'(dv_r2[k][j] - (DEN_W+1)'(dv_ff[k].den));
               dv_in[k+1].quo[j][Q_STEPS-1-k] = 1'b1;
            end else begin
               dv_in[k+1].rem[j] = DEN_W'(dv_r2[k][j]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= SQ_STEPS; k++) sq_vld_ff[k] <= 1'b0;
         for (int k = 0; k <= Q_STEPS; k++) dv_vld_ff[k] <= 1'b0;
      end else begin
         sq_vld_ff[0] <= s1_vld_ff;
         for (int k = 0; k < SQ_STEPS; k++) sq_vld_ff[k+1] <= sq_vld_ff[k];
         dv_vld_ff[0] <= sq_vld_ff[SQ_STEPS];
         for (int k = 0; k < Q_STEPS; k++) dv_vld_ff[k+1] <= dv_vld_ff[k];
      end
      for (int k = 0; k <= SQ_STEPS; k++) sq_ff[k] <= sq_in[k];
      for (int k = 0; k <= Q_STEPS; k++) dv_ff[k] <= dv_in[k];
   end

   // ---------------- saturate, sign and place components ----------------
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         fin_mag[j]  = (dv_ff[Q_STEPS].quo[j] > Q_STEPS'(ONE)) ? Q_STEPS'(ONE)
                                                              : dv_ff[Q_STEPS].quo[j];
         fin_comp[j] = dv_ff[Q_STEPS].neg[j] ? DATA_W'(-fin_mag[j]) : DATA_W'(fin_mag[j]);
      end
      fin_root = (dv_ff[Q_STEPS].c > C_W'(ONE)) ? DATA_W'(ONE) : DATA_W'(dv_ff[Q_STEPS].c);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= dv_vld_ff[Q_STEPS];
      end
      rsp_largest_index <= dv_ff[Q_STEPS].best;
      unique case (dv_ff[Q_STEPS].best)
         IDX_X: begin
            rsp_qx <= fin_root;    rsp_qy <= fin_comp[0];
            rsp_qz <= fin_comp[1]; rsp_qw <= fin_comp[2];
         end
         IDX_Y: begin
            rsp_qx <= fin_comp[0]; rsp_qy <= fin_root;
            rsp_qz <= fin_comp[1]; rsp_qw <= fin_comp[2];
         end
         IDX_Z: begin
            rsp_qx <= fin_comp[0]; rsp_qy <= fin_comp[1];
            rsp_qz <= fin_root;    rsp_qw <= fin_comp[2];
         end
         default: begin
            rsp_qx <= fin_comp[0]; rsp_qy <= fin_comp[1];
            rsp_qz <= fin_comp[2]; rsp_qw <= fin_root;
         end
      endcase
   end

   // ---------------- assertions ----------------
   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_strobe)
      else $error("transfer did not produce a result at the pipeline depth");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_strobe)
      else $error("result strobe right after reset");

   a_root_x: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_largest_index == IDX_X |->
         rsp_qx >= DATA_W'(HALF) && rsp_qx <= DATA_W'(ONE))
      else $error("root component x out of range");

   a_root_w: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_largest_index == IDX_W |->
         rsp_qw >= DATA_W'(HALF) && rsp_qw <= DATA_W'(ONE))
      else $error("root component w out of range");

endmodule

`default_nettype wire

[sim/rmq_checker.sv]
// Checker for rotation_matrix_to_quaternion: watches both channels, predicts quaternions.
// Depends on rmq_pkg for widths and component codes.
`timescale 1ns / 1ps

module rmq_checker (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_start,
   input  wire        busy,
   input  wire [15:0] req_m11, req_m12, req_m13,
   input  wire [15:0] req_m21, req_m22, req_m23,
   input  wire [15:0] req_m31, req_m32, req_m33,
   input  wire        rsp_strobe,
   input  wire [15:0] rsp_qx, rsp_qy, rsp_qz, rsp_qw,
   input  wire [1:0]  rsp_largest_index,
   output int         fail_count,
   output int         pending
);
   import rmq_pkg::*;

   typedef struct {
      logic [15:0] qx, qy, qz, qw;
      logic [1:0]  idx;
   } quat_type;

   quat_type quat_queue[$];

   function automatic longint root_floor(longint v);
      longint r;
      r = 0;
      for (int b = 31; b >= 0; b--)
         if ((r + (64'sd1 <<< b)) * (r + (64'sd1 <<< b)) <= v) r += 64'sd1 <<< b;
      return r;
   endfunction

   function automatic logic [15:0] div_round(longint d, longint den);
      longint mag, q;
      mag = (d < 0 ? -d : d) <<< FRAC_BITS;
      q = (mag + den / 2) / den;
      if (q > ONE) q = ONE;
      return d < 0 ? 16'(-q) : 16'(q);
   endfunction

   function automatic quat_type to_quaternion(longint a11, a12, a13, a21, a22, a23,
                                              a31, a32, a33);
      longint tr[4];
      longint c, den;
      logic [1:0] best;
      quat_type r;
      tr[0] = ONE + a11 - a22 - a33;
      tr[1] = ONE - a11 + a22 - a33;
      tr[2] = ONE - a11 - a22 + a33;
      tr[3] = ONE + a11 + a22 + a33;
      best = IDX_X;
      for (int i = 1; i < 4; i++) if (tr[i] > tr[best]) best = 2'(i);
      c = root_floor(tr[best] <<< FRAC_BITS) >>> 1;
      if (c < 1) c = 1;
      den = 4 * c;
      // root component saturates as well
      case (best)
         IDX_X: begin
            r.qx = 16'(c > ONE ? ONE : c);
            r.qy = div_round(a12 + a21, den);
            r.qz = div_round(a31 + a13, den);
            r.qw = div_round(a23 - a32, den);
         end
         IDX_Y: begin
            r.qx = div_round(a12 + a21, den);
            r.qy = 16'(c > ONE ? ONE : c);
            r.qz = div_round(a23 + a32, den);
            r.qw = div_round(a31 - a13, den);
         end
         IDX_Z: begin
            r.qx = div_round(a31 + a13, den);
            r.qy = div_round(a23 + a32, den);
            r.qz = 16'(c > ONE ? ONE : c);
            r.qw = div_round(a12 - a21, den);
         end
         default: begin
            r.qx = div_round(a23 - a32, den);
            r.qy = div_round(a31 - a13, den);
            r.qz = div_round(a12 - a21, den);
            r.qw = 16'(c > ONE ? ONE : c);
         end
      endcase
      r.idx = best;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, $signed(got),
               $signed(want), $realtime);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      quat_type e;
      if (!reset) begin
         if (req_start && !busy)
            quat_queue.push_back(to_quaternion(
               $signed(req_m11), $signed(req_m12), $signed(req_m13),
               $signed(req_m21), $signed(req_m22), $signed(req_m23),
               $signed(req_m31), $signed(req_m32), $signed(req_m33)));
         if (rsp_strobe) begin
            if (quat_queue.size() == 0) begin
               $display("unexpected result transfer at %0t", $realtime);
               fail_count++;
            end else begin
               e = quat_queue.pop_front();
               if (rsp_qx !== e.qx) report_mismatch("qx", rsp_qx, e.qx);
               if (rsp_qy !== e.qy) report_mismatch("qy", rsp_qy, e.qy);
               if (rsp_qz !== e.qz) report_mismatch("qz", rsp_qz, e.qz);
               if (rsp_qw !== e.qw) report_mismatch("qw", rsp_qw, e.qw);
               if (rsp_largest_index !== e.idx)
                  report_mismatch("largest_index", 16'(rsp_largest_index), 16'(e.idx));
            end
         end
      end
      pending = quat_queue.size();
   end

endmodule

[sim/rotation_matrix_to_quaternion_tb.sv]
// Stimulus and verdict for rotation_matrix_to_quaternion.
// Depends on rmq_pkg, the block and rmq_checker.
`timescale 1ns / 1ps

module rotation_matrix_to_quaternion_tb;
   import rmq_pkg::*;

   logic clock = 0, reset = 1, req_start = 0;
   logic signed [15:0] m[9];
   logic busy, rsp_strobe;
   logic signed [15:0] rsp_qx, rsp_qy, rsp_qz, rsp_qw;
   logic [1:0] rsp_largest_index;
   int fail_count, pending, idle_pct;

   initial begin
      foreach (m[i]) m[i] = 0;
      forever #1 clock = ~clock;
   end

   rotation_matrix_to_quaternion DUT (
      .clock, .reset, .req_start, .busy,
      .req_m11(m[0]), .req_m12(m[1]), .req_m13(m[2]),
      .req_m21(m[3]), .req_m22(m[4]), .req_m23(m[5]),
      .req_m31(m[6]), .req_m32(m[7]), .req_m33(m[8]),
      .rsp_strobe, .rsp_qx, .rsp_qy, .rsp_qz, .rsp_qw, .rsp_largest_index
   );

   rmq_checker rmq_check (
      .clock, .reset, .req_start, .busy,
      .req_m11(m[0]), .req_m12(m[1]), .req_m13(m[2]),
      .req_m21(m[3]), .req_m22(m[4]), .req_m23(m[5]),
      .req_m31(m[6]), .req_m32(m[7]), .req_m33(m[8]),
      .rsp_strobe, .rsp_qx, .rsp_qy, .rsp_qz, .rsp_qw, .rsp_largest_index,
      .fail_count, .pending
   );

   // drive one matrix and hold until the transfer; drop start only while idling
   task automatic send_matrix(input logic signed [15:0] v[9]);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         req_start <= 0;
         @(negedge clock);
      end
      m = v;
      req_start <= 1;
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic signed [15:0] entry_value(int mode);
      case (mode)
         0: return 16'($urandom_range(32768) - 16384);
         1: return 16'($urandom);
         default: return 16'($urandom_range(2000) - 1000);
      endcase
   endfunction

   initial begin
      logic signed [15:0] v[9];
      int mode;
      idle_pct = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 0;
      // identity, each diagonal dominant, extremes, ties, then random entries
      for (int k = 0; k < 20; k++) begin
         foreach (v[i]) v[i] = 0;
         case (k)
            0: begin v[0] = 16'(ONE); v[4] = 16'(ONE); v[8] = 16'(ONE); end
            1: begin v[0] = 16'(ONE); v[4] = 16'(-ONE); v[8] = 16'(-ONE); end
            2: begin v[0] = 16'(-ONE); v[4] = 16'(ONE); v[8] = 16'(-ONE); end
            3: begin v[0] = 16'(-ONE); v[4] = 16'(-ONE); v[8] = 16'(ONE); end
            4: ;
            5: foreach (v[i]) v[i] = 16'(ONE);
            6: foreach (v[i]) v[i] = 16'(-ONE);
            7: foreach (v[i]) v[i] = 16'h7fff;
            8: foreach (v[i]) v[i] = 16'h8000;
            9: begin v[0] = 16'h7fff; v[1] = 16'h8000; v[3] = 16'h8000; end
            10: begin v[0] = 16'h8000; v[4] = 16'h8000; v[8] = 16'h7fff;
               v[5] = 16'h7fff; v[7] = 16'h8000; end
            11: begin v[0] = 16'(ONE); v[4] = 16'(ONE); v[8] = 16'(-ONE); end
            12: begin v[1] = 16'(-ONE); v[3] = 16'(ONE); v[8] = 16'(ONE); end
            13: begin v[2] = 16'(ONE); v[6] = 16'(-ONE); v[4] = 16'(ONE); end
            default: foreach (v[i]) v[i] = entry_value(k % 3);
         endcase
         send_matrix(v);
      end
      // idle phases; hold off once until every result has come
      for (int p = 0; p < 5; p++) begin
         idle_pct = (p == 1) ? 87 : (p == 3) ? 9 : 0;
         for (int n = 0; n < 210; n++) begin
            mode = $urandom_range(3);
            foreach (v[i]) v[i] = entry_value(mode == 3 ? 0 : mode);
            send_matrix(v);
         end
         if (p == 2) begin
            req_start <= 0;
            while (pending != 0) @(negedge clock);
         end
      end
      req_start <= 0;
      while (pending != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
      if (fail_count == 0)
         $display("rotation_matrix_to_quaternion regression: pass");
      else
         $display("rotation_matrix_to_quaternion regression: fail");
      $finish;
   end

   initial begin
      #200000;
      $display("rotation_matrix_to_quaternion regression: fail");
      $finish;
   end

endmodule
